>>> rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is asserted.
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/kli_pkg.sv
package kli_pkg;
	localparam int TIME_W = 24;
	localparam int RATE_W = 16;
	localparam int FRAC_W = 17;
	localparam int KC_W   = 7;
	localparam int THR_W  = 15;
	localparam int CFG_W  = 15;
	localparam int IDX_W  = 6;
	localparam int MODE_W = 2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic REG_KEY_COUNT = 1'b0;
	localparam logic REG_BLEND_THR = 1'b1;

	localparam logic [MODE_W-1:0] MODE_SKIP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FULL  = 2'd2;

	localparam logic signed [RATE_W-1:0] FULL_RATE = 16'sd16384;

	typedef struct packed {
		logic [TIME_W-1:0]        tm;
		logic signed [RATE_W-1:0] rt;
	} key_t;
endpackage

>>> rtl/core/kli_cell.sv
// One keyframe slot of the ring: load on a write, take the neighbor's key on a shift.
module kli_cell (
	input  logic          clk,
	input  logic          ld,
	input  logic          sh,
	input  kli_pkg::key_t ld_key,
	input  kli_pkg::key_t nb_key,
	output kli_pkg::key_t key
);
	import kli_pkg::*;

	key_t key_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			key_q <= ld_key;
		end else if (sh) begin
			key_q <= nb_key;
		end
	end

	assign key = key_q;
endmodule

>>> rtl/core/kli_div.sv
// Restoring divider: quotient of (num << 16) / den, one bit per cycle.
// Requires num <= den, so the quotient fits in FRAC_W bits.
module kli_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kli_pkg::TIME_W-1:0]  num,
	input  logic [kli_pkg::TIME_W-1:0]  den,
	output logic                        done,
	output logic [kli_pkg::FRAC_W-1:0]  quo
);
	import kli_pkg::*;

	localparam int CNT_W = $clog2(FRAC_W + 1);

	logic [TIME_W:0]   rem_q;
	logic [TIME_W-1:0] den_q;
	logic [FRAC_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TIME_W:0]   trial;
	logic              ge;

	always_comb begin
		trial = (cnt_q == CNT_W'(FRAC_W)) ? rem_q : {rem_q[TIME_W-1:0], 1'b0};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(FRAC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

>>> rtl/core/keyframe_linear_interpolator_core.sv
// Piecewise linear keyframe interpolator. Keys (Q16.8 time, Q2.14 rate) sit in a
// ring of MAX_KEYS cells. A write item stores one key and gives no result; writes
// to a slot at or beyond MAX_KEYS are dropped. In a query with keys in use, the
// ring rotates once to fetch the last key in use (clamp bound), once more to scan
// for the bracketing pair, then, unless the right key is taken as is, a bit-serial
// divider computes the fraction, followed by one multiply, one add and the output
// load. Both rotations are full turns, so the ring is back at home position when
// the block goes idle. A finished result waits in the output register while the
// next item transfers.
module keyframe_linear_interpolator_core #(
	parameter int MAX_KEYS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic [kli_pkg::IDX_W-1:0]          key_index,
	input  logic [kli_pkg::TIME_W-1:0]         key_time,
	input  logic signed [kli_pkg::RATE_W-1:0]  key_rate,
	input  logic [kli_pkg::TIME_W-1:0]         query_time,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [kli_pkg::RATE_W-1:0]  rate,
	output logic [kli_pkg::MODE_W-1:0]         apply_mode,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [kli_pkg::CFG_W-1:0]          cfg_wdata
);
	import kli_pkg::*;

	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int NW = $clog2(MAX_KEYS + 1);

	// Sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PASS1 = 3'd1;
	localparam logic [2:0] ST_PASS2 = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_ADD   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	// Configuration
	logic [KC_W-1:0]  key_count_q;
	logic [THR_W-1:0] blend_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KC_W'(1);
			blend_thr_q <= THR_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_COUNT: key_count_q <= cfg_wdata[KC_W-1:0];
				REG_BLEND_THR: blend_thr_q <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Keys in use, limited to the ring size, and the index of the last one
	logic [NW-1:0] n_keys;
	logic [IW-1:0] last_idx;

	always_comb begin
		n_keys   = (32'(key_count_q) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(key_count_q);
		last_idx = IW'(n_keys - NW'(1));
	end

	logic [2:0] state_q;
	logic       in_go;
	logic       wr_go;
	logic       shift;

	assign in_stall = (state_q != ST_IDLE);
	assign in_go    = in_valid && !in_stall;
	assign wr_go    = in_go && (action == ACT_WRITE);
	assign shift    = (state_q == ST_PASS1) || (state_q == ST_PASS2);

	// Ring of key cells; cell 0 is the head the sequencer looks at
	key_t cell_key [MAX_KEYS];
	key_t wr_key;

	assign wr_key = '{tm: key_time, rt: key_rate};

	for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
		kli_cell u_cell (
			.clk    (clk),
			.ld     (wr_go && (32'(key_index) == k)),
			.sh     (shift),
			.ld_key (wr_key),
			.nb_key (cell_key[(k + 1) % MAX_KEYS]),
			.key    (cell_key[k])
		);
	end

	key_t head;
	assign head = cell_key[0];

	// Query datapath
	logic [IW-1:0]                   ptr_q;
	logic [TIME_W-1:0]               f_q;
	logic [TIME_W-1:0]               t0_q, t1_q;
	logic signed [RATE_W-1:0]        r0_q, r1_q;
	logic                            found_q;
	logic                            hit0_q;
	logic signed [RATE_W-1:0]        res_q;
	logic [FRAC_W-1:0]               frac_q;
	logic signed [RATE_W+FRAC_W+1:0] prod_s1;
	logic                            ptr_end;
	logic                            div_start;
	logic                            div_done;
	logic [FRAC_W-1:0]               div_quo;
	logic                            direct;
	logic                            out_free;
	logic signed [RATE_W:0]          rdiff;
	logic signed [RATE_W+2:0]        rsum;

	assign ptr_end   = (ptr_q == IW'(MAX_KEYS - 1));
	// First key, single key, or a degenerate pair: take the right key as is
	assign direct    = hit0_q || (t1_q <= t0_q) || (f_q <= t0_q);
	assign div_start = (state_q == ST_CHK) && !direct;
	assign out_free  = !out_valid || !out_stall;
	assign rdiff     = RATE_W'(0) + ({r1_q[RATE_W-1], r1_q} - {r0_q[RATE_W-1], r0_q});
	assign rsum      = {{3{r0_q[RATE_W-1]}}, r0_q} + prod_s1[RATE_W+FRAC_W+1:FRAC_W-1];

	kli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (f_q - t0_q),
		.den    (t1_q - t0_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_go && (action == ACT_QUERY)) begin
						ptr_q   <= '0;
						found_q <= 1'b0;
						state_q <= (n_keys == '0) ? ST_FIN : ST_PASS1;
					end
				end
				ST_PASS1: begin
					ptr_q <= ptr_end ? '0 : ptr_q + 1'b1;
					if (ptr_end) begin
						state_q <= ST_PASS2;
					end
				end
				ST_PASS2: begin
					if (!found_q && ((ptr_q == last_idx) || (f_q <= head.tm))) begin
						found_q <= 1'b1;
					end
					ptr_q <= ptr_end ? '0 : ptr_q + 1'b1;
					if (ptr_end) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: state_q <= direct ? ST_FIN : ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				f_q   <= query_time;
				res_q <= '0;
			end
			ST_PASS1: begin
				// clamp the frame to the last key in use
				if ((ptr_q == last_idx) && (f_q > head.tm)) begin
					f_q <= head.tm;
				end
			end
			ST_PASS2: begin
				if (!found_q) begin
					if ((ptr_q == last_idx) || (f_q <= head.tm)) begin
						t1_q   <= head.tm;
						r1_q   <= head.rt;
						hit0_q <= (ptr_q == '0);
					end else begin
						t0_q <= head.tm;
						r0_q <= head.rt;
					end
				end
			end
			ST_CHK: res_q <= r1_q;
			ST_DIV: begin
				if (div_done) begin
					frac_q <= div_quo;
				end
			end
			ST_MUL: prod_s1 <= rdiff * $signed({1'b0, frac_q});
			ST_ADD: res_q <= rsum[RATE_W-1:0];
			default: ;
		endcase
	end

	// Output register
	logic                      out_valid_q;
	logic signed [RATE_W-1:0]  rate_q;
	logic [MODE_W-1:0]         mode_q;
	logic                      fin_go;

	assign fin_go = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			rate_q <= res_q;
			if (res_q == FULL_RATE) begin
				mode_q <= MODE_FULL;
			end else if (res_q > $signed({1'b0, blend_thr_q})) begin
				mode_q <= MODE_BLEND;
			end else begin
				mode_q <= MODE_SKIP;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign rate       = rate_q;
	assign apply_mode = mode_q;
endmodule

>>> rtl/core/kli_checker.sv
`include "assert_macros.svh"

module kli_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               action,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [kli_pkg::RATE_W-1:0]  rate,
	input logic [kli_pkg::MODE_W-1:0]         apply_mode
);
	import kli_pkg::*;

	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(rate) && $stable(apply_mode), "stalled result changed")
	`AST_SAME(a_full_mode, clk, arst_n, out_valid, (rate == FULL_RATE) == (apply_mode == MODE_FULL), "full mode does not match rate")
	`AST_SAME(a_mode_code, clk, arst_n, out_valid, apply_mode == MODE_SKIP || apply_mode == MODE_BLEND || apply_mode == MODE_FULL, "bad apply mode")
	`AST_NEXT(a_write_quiet, clk, arst_n, in_valid && !in_stall && action == ACT_WRITE && !out_valid, !out_valid, "write transfer produced a result")
endmodule

bind keyframe_linear_interpolator_core kli_checker u_kli_checker (.*);
